### design/rv64ie_pkg.sv
// ----------------------------------------------------------------------------
// rv64ie_pkg
// Shared types, operation codes and helpers of the RV64IM integer execute unit.
// ----------------------------------------------------------------------------
package rv64ie_pkg;

    localparam int XLEN       = 64;
    // one quotient bit per divider stage
    localparam int DIV_STAGES = XLEN;
    // index of the output stage
    localparam int LAST       = DIV_STAGES + 1;

    typedef enum logic [5:0] {
        OP_ADD = 6'd0, OP_SUB, OP_SLL, OP_SLT, OP_SLTU, OP_XOR,
        OP_SRL, OP_SRA, OP_OR, OP_AND, OP_MUL, OP_MULH,
        OP_MULHSU, OP_MULHU, OP_DIV, OP_DIVU, OP_REM, OP_REMU,
        OP_ADDW, OP_SUBW, OP_SLLW, OP_SRLW, OP_SRAW, OP_MULW,
        OP_DIVW, OP_DIVUW, OP_REMW, OP_REMUW,
        OP_ADDI, OP_SLTI, OP_SLTIU, OP_XORI, OP_ORI, OP_ANDI,
        OP_SLLI, OP_SRLI, OP_SRAI,
        OP_ADDIW, OP_SLLIW, OP_SRLIW, OP_SRAIW,
        OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU
    } t_op;

    // which part of the product a multiply returns
    typedef enum logic [1:0] {
        MK_LO, MK_HI, MK_W
    } t_mul;

    // control and early results that travel down the pipeline
    typedef struct packed {
        logic            valid;
        logic            is_mul;
        t_mul            mkind;
        logic            is_div;
        logic            is_rem;
        logic            neg_q;
        logic            neg_r;
        logic            div0;
        logic            wform;
        logic [XLEN-1:0] res;
        logic            rdw;
        logic [XLEN-1:0] npc;
        logic            taken;
        logic            ill;
        logic [31:0]     tval;
    } t_meta;

    // restoring divider state
    typedef struct packed {
        logic [XLEN-1:0] rem;
        logic [XLEN-1:0] quo;
        logic [XLEN-1:0] dsr;
    } t_div;

    function automatic logic [XLEN-1:0] f_sext32(input logic [XLEN-1:0] x);
        return {{(XLEN-32){x[31]}}, x[31:0]};
    endfunction

endpackage

### design/rv64im_integer_execute_top.sv
// ----------------------------------------------------------------------------
// rv64im_integer_execute_top
// Pipelined RV64IM integer execute: ALU, branches, multiply and divide.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid / o_ready carries one decoded operation per
//   transaction: mode, both source values, immediate, pc and instruction word.
//   Output channel o_valid / i_ready returns exactly one result transaction
//   per input, in order.
//   Every operation passes through the same 66 register stages: one
//   decode/ALU stage, 64 restoring divider stages (one quotient bit each) and
//   a result stage.
//   Multiplies use four 32x32 partial products, a summing stage and a
//   correction stage inside the same pipeline.
//   Throughput is one transaction per cycle while the output is not stalled;
//   all operations share the 66-stage pipeline so results never reorder.
//   When the receiver stalls with a result waiting, the whole pipeline holds;
//   o_ready is low only in that case.
//   Reset clears all valid bits; the unit is ready in the first cycle after.
// ----------------------------------------------------------------------------
module rv64im_integer_execute_top
    import rv64ie_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [5:0]  i_mode,
    input  logic [63:0] i_rs1_value,
    input  logic [63:0] i_rs2_value,
    input  logic signed [12:0] i_immediate,
    input  logic [63:0] i_pc_in,
    input  logic [31:0] i_instr_word,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_rd_value,
    output logic        o_rd_write,
    output logic [63:0] o_next_pc,
    output logic        o_branch_taken,
    output logic        o_illegal,
    output logic [31:0] o_trap_value
);

    logic en;

    t_meta r_mt [0:LAST];
    t_meta n_mt [0:LAST];
    t_div  r_dv [0:DIV_STAGES];
    t_div  n_dv [0:DIV_STAGES];

    // stage 0 next values from the decode logic
    t_meta n_mt0;
    t_div  n_dv0;

    // multiplier side path
    logic [63:0]  r_ma, r_mb, n_ma, n_mb;
    logic         r_msa, r_msb, n_msa, n_msb;
    logic [63:0]  r_pp [0:3];
    logic [63:0]  r_corr1, r_corr2;
    logic [127:0] r_prod;

    // pipeline moves unless a result waits at the output
    assign en      = !r_mt[LAST].valid || i_ready;
    assign o_ready = en;

    // decode, alu, branch and operand preparation
    always_comb begin
        logic [63:0] a, b, imm, sa, sb;
        logic [31:0] w32;
        logic        sgn, wf, cond;
        t_op         op;
        a    = i_rs1_value;
        b    = i_rs2_value;
        imm  = {{51{i_immediate[12]}}, i_immediate};
        op   = t_op'(i_mode);
        w32  = '0;
        cond = 1'b0;
        sgn  = 1'b0;
        wf   = 1'b0;
        n_ma = a;
        n_mb = b;
        n_msa = 1'b0;
        n_msb = 1'b0;
        n_mt0       = '0;
        n_mt0.valid = i_valid;
        n_mt0.rdw   = 1'b1;
        n_mt0.npc   = i_pc_in + 64'd4;
        unique case (op)
            OP_ADD:    n_mt0.res = a + b;
            OP_SUB:    n_mt0.res = a - b;
            OP_SLL:    n_mt0.res = a << b[5:0];
            OP_SLT:    n_mt0.res = {63'd0, $signed(a) < $signed(b)};
            OP_SLTU:   n_mt0.res = {63'd0, a < b};
            OP_XOR:    n_mt0.res = a ^ b;
            OP_SRL:    n_mt0.res = a >> b[5:0];
            OP_SRA:    n_mt0.res = 64'($signed(a) >>> b[5:0]);
            OP_OR:     n_mt0.res = a | b;
            OP_AND:    n_mt0.res = a & b;
            OP_MUL:    n_mt0.is_mul = 1'b1;
            OP_MULH: begin
                n_mt0.is_mul = 1'b1;
                n_mt0.mkind  = MK_HI;
                n_msa = 1'b1;
                n_msb = 1'b1;
            end
            OP_MULHSU: begin
                n_mt0.is_mul = 1'b1;
                n_mt0.mkind  = MK_HI;
                n_msa = 1'b1;
            end
            OP_MULHU: begin
                n_mt0.is_mul = 1'b1;
                n_mt0.mkind  = MK_HI;
            end
            OP_DIV:    begin n_mt0.is_div = 1'b1; sgn = 1'b1; end
            OP_DIVU:   n_mt0.is_div = 1'b1;
            OP_REM:    begin n_mt0.is_div = 1'b1; n_mt0.is_rem = 1'b1; sgn = 1'b1; end
            OP_REMU:   begin n_mt0.is_div = 1'b1; n_mt0.is_rem = 1'b1; end
            OP_ADDW:   n_mt0.res = f_sext32(a + b);
            OP_SUBW:   n_mt0.res = f_sext32(a - b);
            OP_SLLW:   n_mt0.res = f_sext32(a << b[4:0]);
            OP_SRLW: begin
                w32 = a[31:0] >> b[4:0];
                n_mt0.res = f_sext32({32'd0, w32});
            end
            OP_SRAW: begin
                w32 = 32'($signed(a[31:0]) >>> b[4:0]);
                n_mt0.res = f_sext32({32'd0, w32});
            end
            OP_MULW: begin
                n_mt0.is_mul = 1'b1;
                n_mt0.mkind  = MK_W;
            end
            OP_DIVW:   begin n_mt0.is_div = 1'b1; sgn = 1'b1; wf = 1'b1; end
            OP_DIVUW:  begin n_mt0.is_div = 1'b1; wf = 1'b1; end
            OP_REMW: begin
                n_mt0.is_div = 1'b1;
                n_mt0.is_rem = 1'b1;
                sgn = 1'b1;
                wf  = 1'b1;
            end
            OP_REMUW:  begin n_mt0.is_div = 1'b1; n_mt0.is_rem = 1'b1; wf = 1'b1; end
            OP_ADDI:   n_mt0.res = a + imm;
            OP_SLTI:   n_mt0.res = {63'd0, $signed(a) < $signed(imm)};
            OP_SLTIU:  n_mt0.res = {63'd0, a < imm};
            OP_XORI:   n_mt0.res = a ^ imm;
            OP_ORI:    n_mt0.res = a | imm;
            OP_ANDI:   n_mt0.res = a & imm;
            OP_SLLI:   n_mt0.res = a << imm[5:0];
            OP_SRLI:   n_mt0.res = a >> imm[5:0];
            OP_SRAI:   n_mt0.res = 64'($signed(a) >>> imm[5:0]);
            OP_ADDIW:  n_mt0.res = f_sext32(a + imm);
            OP_SLLIW:  n_mt0.res = f_sext32(a << imm[4:0]);
            OP_SRLIW: begin
                w32 = a[31:0] >> imm[4:0];
                n_mt0.res = f_sext32({32'd0, w32});
            end
            OP_SRAIW: begin
                w32 = 32'($signed(a[31:0]) >>> imm[4:0]);
                n_mt0.res = f_sext32({32'd0, w32});
            end
            OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU: begin
                unique case (op)
                    OP_BEQ:  cond = (a == b);
                    OP_BNE:  cond = (a != b);
                    OP_BLT:  cond = $signed(a) < $signed(b);
                    OP_BGE:  cond = !($signed(a) < $signed(b));
                    OP_BLTU: cond = a < b;
                    default: cond = a >= b;
                endcase
                n_mt0.rdw   = 1'b0;
                n_mt0.taken = cond;
                if (cond) begin
                    n_mt0.npc = i_pc_in + imm;
                end
            end
            default: begin
                n_mt0.rdw  = 1'b0;
                n_mt0.ill  = 1'b1;
                n_mt0.npc  = '0;
                n_mt0.tval = i_instr_word;
            end
        endcase
        // divider operands: magnitudes plus sign fixups
        if (wf) begin
            sa = sgn ? f_sext32(a) : {32'd0, a[31:0]};
            sb = sgn ? f_sext32(b) : {32'd0, b[31:0]};
        end else begin
            sa = a;
            sb = b;
        end
        n_mt0.wform = wf;
        n_mt0.div0  = (sb == '0);
        n_mt0.neg_r = sgn && sa[63];
        n_mt0.neg_q = sgn && (sa[63] ^ sb[63]);
        n_dv0.rem   = '0;
        n_dv0.quo   = (sgn && sa[63]) ? -sa : sa;
        n_dv0.dsr   = (sgn && sb[63]) ? -sb : sb;
    end

    // restoring divider, one quotient bit per stage
    always_comb begin
        logic [64:0] trial;
        trial = '0;
        n_dv[0] = n_dv0;
        for (int k = 1; k <= DIV_STAGES; k++) begin
            trial = {r_dv[k-1].rem, r_dv[k-1].quo[63]} - {1'b0, r_dv[k-1].dsr};
            n_dv[k].dsr = r_dv[k-1].dsr;
            if (!trial[64]) begin
                n_dv[k].rem = trial[63:0];
                n_dv[k].quo = {r_dv[k-1].quo[62:0], 1'b1};
            end else begin
                n_dv[k].rem = {r_dv[k-1].rem[62:0], r_dv[k-1].quo[63]};
                n_dv[k].quo = {r_dv[k-1].quo[62:0], 1'b0};
            end
        end
    end

    // meta travels down; multiply result joins at stage 3, divide at the end
    always_comb begin
        logic [63:0] q, r, v;
        q = '0;
        r = '0;
        v = '0;
        n_mt[0] = n_mt0;
        for (int k = 1; k <= LAST; k++) begin
            n_mt[k] = r_mt[k-1];
        end
        if (r_mt[2].is_mul) begin
            unique case (r_mt[2].mkind)
                MK_HI:   n_mt[3].res = r_prod[127:64] - r_corr2;
                MK_W:    n_mt[3].res = f_sext32(r_prod[63:0]);
                default: n_mt[3].res = r_prod[63:0];
            endcase
        end
        if (r_mt[LAST-1].is_div) begin
            q = r_mt[LAST-1].div0 ? '1 :
                (r_mt[LAST-1].neg_q ? -r_dv[DIV_STAGES].quo : r_dv[DIV_STAGES].quo);
            r = r_mt[LAST-1].neg_r ? -r_dv[DIV_STAGES].rem : r_dv[DIV_STAGES].rem;
            v = r_mt[LAST-1].is_rem ? r : q;
            n_mt[LAST].res = r_mt[LAST-1].wform ? f_sext32(v) : v;
        end
    end

    // pipeline registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= LAST; k++) begin
                r_mt[k].valid <= 1'b0;
            end
        end else if (en) begin
            for (int k = 0; k <= LAST; k++) begin
                r_mt[k] <= n_mt[k];
            end
        end
    end

    // payload registers: divider and multiplier data
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k <= DIV_STAGES; k++) begin
                r_dv[k] <= n_dv[k];
            end
            r_ma  <= n_ma;
            r_mb  <= n_mb;
            r_msa <= n_msa;
            r_msb <= n_msb;
            // partial products
            r_pp[0] <= r_ma[31:0]  * r_mb[31:0];
            r_pp[1] <= r_ma[31:0]  * r_mb[63:32];
            r_pp[2] <= r_ma[63:32] * r_mb[31:0];
            r_pp[3] <= r_ma[63:32] * r_mb[63:32];
            r_corr1 <= ((r_msa && r_ma[63]) ? r_mb : 64'd0)
                     + ((r_msb && r_mb[63]) ? r_ma : 64'd0);
            // product sum
            r_prod  <= {r_pp[3], r_pp[0]}
                     + {32'd0, r_pp[1], 32'd0}
                     + {32'd0, r_pp[2], 32'd0};
            r_corr2 <= r_corr1;
        end
    end

    // outputs
    assign o_valid        = r_mt[LAST].valid;
    assign o_rd_value     = r_mt[LAST].res;
    assign o_rd_write     = r_mt[LAST].rdw;
    assign o_next_pc      = r_mt[LAST].npc;
    assign o_branch_taken = r_mt[LAST].taken;
    assign o_illegal      = r_mt[LAST].ill;
    assign o_trap_value   = r_mt[LAST].tval;

endmodule
